// ===== rtl/chg_ovp_pkg.sv =====
// ----------------------------------------------------------------------------
// chg_ovp_pkg
// Shared types and constants of the charger overvoltage / FET control block:
// field widths, register map, reset values and protection state codes.
// ----------------------------------------------------------------------------
package chg_ovp_pkg;

	// field widths
	localparam int SAMPLE_W  = 10;
	localparam int GAIN_W    = 14;
	localparam int OFFSET_W  = 13;
	localparam int MV_W      = 16;
	localparam int COUNT_W   = 16;
	localparam int HOLD_W    = 20;
	localparam int PSTATE_W  = 3;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;

	// Q8 fraction bits of the gain
	localparam int GAIN_FRAC = 8;

	// register indexes (byte address is 4 times the index)
	localparam logic [REG_IDX_W-1:0] REG_CAL_GAIN     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CAL_OFFSET   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OVP_THRESH   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CUTOFF       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ABSENT       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OVP_CONFIRM  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OVP_HOLD     = 3'd6;

	// register reset values
	localparam logic [GAIN_W-1:0]          CAL_GAIN_RST    = 14'd6637;
	localparam logic signed [OFFSET_W-1:0] CAL_OFFSET_RST  = -13'sd82;
	localparam logic [MV_W-1:0]            OVP_THRESH_RST  = 16'd15000;
	localparam logic [MV_W-1:0]            CUTOFF_RST      = 16'd13000;
	localparam logic [MV_W-1:0]            ABSENT_RST      = 16'd1000;
	localparam logic [COUNT_W-1:0]         OVP_CONFIRM_RST = 16'd15000;
	localparam logic [HOLD_W-1:0]          OVP_HOLD_RST    = 20'd100000;

	// protection state codes
	localparam logic [PSTATE_W-1:0] PS_CHARGING = 3'd0;
	localparam logic [PSTATE_W-1:0] PS_CUTOFF   = 3'd1;
	localparam logic [PSTATE_W-1:0] PS_ABSENT   = 3'd2;
	localparam logic [PSTATE_W-1:0] PS_PENDING  = 3'd3;
	localparam logic [PSTATE_W-1:0] PS_TRIPPED  = 3'd4;
	localparam logic [PSTATE_W-1:0] PS_HOLD     = 3'd5;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [GAIN_W-1:0]          cal_gain_q8;
		logic signed [OFFSET_W-1:0] cal_offset_mv;
		logic [MV_W-1:0]            ovp_threshold_mv;
		logic [MV_W-1:0]            cutoff_mv;
		logic [MV_W-1:0]            absent_mv;
		logic [COUNT_W-1:0]         ovp_confirm_count;
		logic [HOLD_W-1:0]          ovp_hold_count;
	} cfg_t;

endpackage

// ===== rtl/chg_ovp_if.sv =====
// ----------------------------------------------------------------------------
// chg_ovp_if
// Valid/ready channels of the block: sample requests in, result requests out.
// ----------------------------------------------------------------------------
interface chg_ovp_in_if import chg_ovp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] battery_sample;
	logic                blink_level;

	modport source (output valid, output battery_sample, output blink_level, input ready);
	modport sink (input valid, input battery_sample, input blink_level, output ready);
endinterface

interface chg_ovp_out_if import chg_ovp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                fet_on;
	logic                led_on;
	logic [MV_W-1:0]     battery_mv;
	logic [PSTATE_W-1:0] protect_state;

	modport source (output valid, output fet_on, output led_on, output battery_mv,
		output protect_state, input ready);
	modport sink (input valid, input fet_on, input led_on, input battery_mv,
		input protect_state, output ready);
endinterface

// ===== rtl/chg_ovp_regs.sv =====
// ----------------------------------------------------------------------------
// chg_ovp_regs
// APB-style register file holding calibration and protection settings.
// ----------------------------------------------------------------------------
module chg_ovp_regs import chg_ovp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_gain_q8       <= CAL_GAIN_RST;
			cfg_q.cal_offset_mv     <= CAL_OFFSET_RST;
			cfg_q.ovp_threshold_mv  <= OVP_THRESH_RST;
			cfg_q.cutoff_mv         <= CUTOFF_RST;
			cfg_q.absent_mv         <= ABSENT_RST;
			cfg_q.ovp_confirm_count <= OVP_CONFIRM_RST;
			cfg_q.ovp_hold_count    <= OVP_HOLD_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_CAL_GAIN:    cfg_q.cal_gain_q8       <= pwdata[GAIN_W-1:0];
				REG_CAL_OFFSET:  cfg_q.cal_offset_mv     <= $signed(pwdata[OFFSET_W-1:0]);
				REG_OVP_THRESH:  cfg_q.ovp_threshold_mv  <= pwdata[MV_W-1:0];
				REG_CUTOFF:      cfg_q.cutoff_mv         <= pwdata[MV_W-1:0];
				REG_ABSENT:      cfg_q.absent_mv         <= pwdata[MV_W-1:0];
				REG_OVP_CONFIRM: cfg_q.ovp_confirm_count <= pwdata[COUNT_W-1:0];
				REG_OVP_HOLD:    cfg_q.ovp_hold_count    <= pwdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_CAL_GAIN:    prdata = PDATA_W'(cfg_q.cal_gain_q8);
			REG_CAL_OFFSET:  prdata = PDATA_W'(cfg_q.cal_offset_mv);
			REG_OVP_THRESH:  prdata = PDATA_W'(cfg_q.ovp_threshold_mv);
			REG_CUTOFF:      prdata = PDATA_W'(cfg_q.cutoff_mv);
			REG_ABSENT:      prdata = PDATA_W'(cfg_q.absent_mv);
			REG_OVP_CONFIRM: prdata = PDATA_W'(cfg_q.ovp_confirm_count);
			REG_OVP_HOLD:    prdata = PDATA_W'(cfg_q.ovp_hold_count);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/chg_ovp_avg.sv =====
// ----------------------------------------------------------------------------
// chg_ovp_avg
// Sample accumulator and truncating divide by the group size. The divide is
// a reciprocal multiply followed by a one-step remainder correction.
// ----------------------------------------------------------------------------
module chg_ovp_avg import chg_ovp_pkg::*; #(
	parameter int AVG_COUNT   = 10,
	parameter int SAMPLE_BITS = 10,
	localparam int AVG_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] battery_sample,
	input  logic                blink_level,
	output logic                avg_valid,
	input  logic                avg_ready,
	output logic [AVG_W-1:0]    avg,
	output logic                avg_blink
);

	localparam int SUM_MAX = AVG_COUNT * ((1 << AVG_W) - 1);
	localparam int SUM_W   = $clog2(SUM_MAX + 1);
	localparam int CNT_W   = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
	localparam int RECIP_S = SUM_W;
	localparam int RECIP_W = RECIP_S + 1;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((1 << RECIP_S) / AVG_COUNT);
	localparam int QPROD_W = SUM_W + RECIP_W;

	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic               last;
	logic               in_fire;
	logic [SUM_W-1:0]   total;
	logic               rdy_s1, rdy_s2, rdy_s3;
	logic               v_s1, v_s2, v_s3;
	logic [SUM_W-1:0]   total_s1, total_s2;
	logic               blink_s1, blink_s2, blink_s3;
	logic [QPROD_W-1:0] qprod;
	logic [AVG_W-1:0]   quot_s2;
	logic [SUM_W-1:0]   rem;
	logic [AVG_W-1:0]   avg_s3;

	// stage handshakes
	assign rdy_s3   = !v_s3 || avg_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign in_fire  = in_valid && rdy_s1;

	// running sum, closing sample of a group
	assign last  = (count_q == CNT_W'(AVG_COUNT - 1));
	assign total = sum_q + SUM_W'(battery_sample[AVG_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (in_fire) begin
			if (last) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= total;
			end
		end
	end

	// reciprocal estimate, never above the true quotient and at most one below
	assign qprod = QPROD_W'(total_s1) * QPROD_W'(RECIP_M);

	// remainder correction
	assign rem    = total_s2 - SUM_W'(quot_s2) * SUM_W'(AVG_COUNT);
	assign avg_s3 = quot_s2 + AVG_W'(rem >= SUM_W'(AVG_COUNT));

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_fire && last;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			total_s1 <= total;
			blink_s1 <= blink_level;
		end
		if (rdy_s2) begin
			quot_s2  <= qprod[RECIP_S +: AVG_W];
			total_s2 <= total_s1;
			blink_s2 <= blink_s1;
		end
		if (rdy_s3) begin
			avg      <= avg_s3;
			blink_s3 <= blink_s2;
		end
	end

	assign avg_valid = v_s3;
	assign avg_blink = blink_s3;

	// a sample that does not close its group never enters the pipe
	a_no_early_group: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !last |=> !v_s1)
		else $error("partial group entered averaging pipe");

endmodule

// ===== rtl/chg_ovp_cal.sv =====
// ----------------------------------------------------------------------------
// chg_ovp_cal
// Calibration of the average to millivolts: Q8 gain multiply, offset add and
// clamp to the 16-bit range, with a register after the multiply and one after the clamp.
// ----------------------------------------------------------------------------
module chg_ovp_cal import chg_ovp_pkg::*; #(
	parameter int AVG_W = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            avg_valid,
	output logic            avg_ready,
	input  logic [AVG_W-1:0] avg,
	input  logic            avg_blink,
	output logic            mv_valid,
	input  logic            mv_ready,
	output logic [MV_W-1:0] mv,
	output logic            mv_blink
);

	localparam int PROD_W = AVG_W + GAIN_W;
	localparam int SUM_W  = MV_W + 2;

	logic                    rdy_s4, rdy_s5;
	logic                    v_s4, v_s5;
	logic [PROD_W-1:0]       prod_s4;
	logic                    blink_s4, blink_s5;
	logic [MV_W-1:0]         scaled;
	logic signed [SUM_W-1:0] off_ext;
	logic signed [SUM_W-1:0] mv_sum;
	logic [MV_W-1:0]         mv_clamp;

	assign rdy_s5    = !v_s5 || mv_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign avg_ready = rdy_s4;

	// floor of the Q8 product plus signed offset, clamped
	assign scaled  = MV_W'(prod_s4 >> GAIN_FRAC);
	assign off_ext = {{(SUM_W - OFFSET_W){cfg.cal_offset_mv[OFFSET_W-1]}}, cfg.cal_offset_mv};
	assign mv_sum  = $signed({2'b00, scaled}) + off_ext;

	always_comb begin
		if (mv_sum[SUM_W-1]) begin
			mv_clamp = '0;
		end else if (mv_sum[SUM_W-2]) begin
			mv_clamp = '1;
		end else begin
			mv_clamp = mv_sum[MV_W-1:0];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) v_s4 <= avg_valid;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			prod_s4  <= PROD_W'(avg) * PROD_W'(cfg.cal_gain_q8);
			blink_s4 <= avg_blink;
		end
		if (rdy_s5) begin
			mv       <= mv_clamp;
			blink_s5 <= blink_s4;
		end
	end

	assign mv_valid = v_s5;
	assign mv_blink = blink_s5;

endmodule

// ===== rtl/chg_ovp_prot.sv =====
// ----------------------------------------------------------------------------
// chg_ovp_prot
// Protection decision per averaged voltage: overvoltage confirm counter, hold
// countdown, FET and LED levels, and the result register.
// ----------------------------------------------------------------------------
module chg_ovp_prot import chg_ovp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                mv_valid,
	output logic                mv_ready,
	input  logic [MV_W-1:0]     mv,
	input  logic                mv_blink,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                fet_on,
	output logic                led_on,
	output logic [MV_W-1:0]     battery_mv,
	output logic [PSTATE_W-1:0] protect_state
);

	logic                out_valid_q;
	logic                fire;
	logic                ov;
	logic [COUNT_W-1:0]  ovp_q, ovp_d, cnt_inc;
	logic [HOLD_W-1:0]   hold_q, hold_d;
	logic                fet_q, fet_d;
	logic                led_q, led_d;
	logic [PSTATE_W-1:0] ps_d;
	logic [MV_W-1:0]     mv_q;
	logic [PSTATE_W-1:0] ps_q;

	assign mv_ready = !out_valid_q || out_ready;
	assign fire     = mv_valid && mv_ready;

	// decision for one evaluation
	assign ov      = (mv >= cfg.ovp_threshold_mv);
	assign cnt_inc = (ovp_q == '1) ? ovp_q : ovp_q + 1'b1;

	always_comb begin
		ovp_d  = ovp_q;
		hold_d = hold_q;
		fet_d  = fet_q;
		led_d  = led_q;
		ps_d   = PS_CHARGING;
		if (ov) begin
			if (cnt_inc >= cfg.ovp_confirm_count) begin
				ovp_d  = cfg.ovp_confirm_count;
				hold_d = cfg.ovp_hold_count;
				fet_d  = 1'b0;
				led_d  = mv_blink;
				ps_d   = PS_TRIPPED;
			end else begin
				ovp_d = cnt_inc;
				ps_d  = PS_PENDING;
			end
		end else begin
			ovp_d = '0;
			if (hold_q != '0) begin
				hold_d = hold_q - 1'b1;
				led_d  = mv_blink;
				ps_d   = PS_HOLD;
			end else if (mv <= cfg.absent_mv) begin
				fet_d = 1'b0;
				led_d = 1'b0;
				ps_d  = PS_ABSENT;
			end else if (mv >= cfg.cutoff_mv) begin
				fet_d = 1'b0;
				led_d = 1'b0;
				ps_d  = PS_CUTOFF;
			end else begin
				fet_d = 1'b1;
				led_d = 1'b1;
				ps_d  = PS_CHARGING;
			end
		end
	end

	// protection state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ovp_q       <= '0;
			hold_q      <= '0;
			fet_q       <= 1'b0;
			led_q       <= 1'b0;
		end else begin
			if (mv_ready) out_valid_q <= mv_valid;
			if (fire) begin
				ovp_q  <= ovp_d;
				hold_q <= hold_d;
				fet_q  <= fet_d;
				led_q  <= led_d;
			end
		end
	end

	// result payload; fet and led levels double as the result fields
	always_ff @(posedge clk) begin
		if (fire) begin
			mv_q <= mv;
			ps_q <= ps_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign fet_on        = fet_q;
	assign led_on        = led_q;
	assign battery_mv    = mv_q;
	assign protect_state = ps_q;

	a_trip_fet_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ps_q == PS_TRIPPED |-> !fet_q)
		else $error("FET on in tripped result");

	a_charge_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ps_q == PS_CHARGING |-> fet_q && led_q)
		else $error("charging result without FET and LED on");

	a_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !ov && hold_q != '0 |=> hold_q == $past(hold_q) - 1'b1)
		else $error("hold countdown did not step");

endmodule

// ===== rtl/charger_overvoltage_fet_control.sv =====
// ----------------------------------------------------------------------------
// charger_overvoltage_fet_control
// Averages battery ADC samples in groups, calibrates to millivolts and drives
// the charging FET and LED with overvoltage confirm, trip and hold.
// ----------------------------------------------------------------------------
//  channel     dir  handshake         payload
//  sample_in   in   valid/ready       battery_sample, blink_level
//  result_out  out  valid/ready       fet_on, led_on, battery_mv, protect_state
//  apb         in   psel/penable      paddr, pwdata, prdata (pready tied high)
//
//  one sample request per cycle unless stalled, set by the single-add accumulator
//  the group's last sample passes the input stage, two divide stages, gain
//  multiply, offset/clamp and the decision register before its result appears
//  reset clears the running sum, counters, FET and LED; registers take defaults
//  each stage holds while the next is full; samples stall only when all are full
// ----------------------------------------------------------------------------
module charger_overvoltage_fet_control import chg_ovp_pkg::*; #(
	parameter int AVG_COUNT   = 10,
	parameter int SAMPLE_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	chg_ovp_in_if.sink         sample_in,
	chg_ovp_out_if.source      result_out
);

	localparam int AVG_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

	cfg_t             cfg;
	logic             avg_valid, avg_ready, avg_blink;
	logic [AVG_W-1:0] avg;
	logic             mv_valid, mv_ready, mv_blink;
	logic [MV_W-1:0]  mv;

	// configuration registers
	chg_ovp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// group average
	chg_ovp_avg #(
		.AVG_COUNT   (AVG_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_avg (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (sample_in.valid),
		.in_ready       (sample_in.ready),
		.battery_sample (sample_in.battery_sample),
		.blink_level    (sample_in.blink_level),
		.avg_valid      (avg_valid),
		.avg_ready      (avg_ready),
		.avg            (avg),
		.avg_blink      (avg_blink)
	);

	// millivolt calibration
	chg_ovp_cal #(
		.AVG_W (AVG_W)
	) u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.avg_valid (avg_valid),
		.avg_ready (avg_ready),
		.avg       (avg),
		.avg_blink (avg_blink),
		.mv_valid  (mv_valid),
		.mv_ready  (mv_ready),
		.mv        (mv),
		.mv_blink  (mv_blink)
	);

	// protection decision and result register
	chg_ovp_prot u_prot (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.mv_valid      (mv_valid),
		.mv_ready      (mv_ready),
		.mv            (mv),
		.mv_blink      (mv_blink),
		.out_valid     (result_out.valid),
		.out_ready     (result_out.ready),
		.fet_on        (result_out.fet_on),
		.led_on        (result_out.led_on),
		.battery_mv    (result_out.battery_mv),
		.protect_state (result_out.protect_state)
	);

endmodule
